// ===== src/ioexp_pkg.sv =====
package ioexp_pkg;

	localparam int unsigned NUM_PORTS = 3;
	localparam int unsigned PORT_W    = 8;
	localparam int unsigned PIN_COUNT = NUM_PORTS * PORT_W;

	// bus command codes
	localparam logic [1:0] CMD_WRITE = 2'd0;
	localparam logic [1:0] CMD_READ  = 2'd1;
	localparam logic [1:0] CMD_PIN   = 2'd2;
	localparam logic [1:0] CMD_NOP   = 2'd3;

	// register groups, pointer bits 3..2
	localparam logic [1:0] GRP_INPUT    = 2'd0;
	localparam logic [1:0] GRP_OUTPUT   = 2'd1;
	localparam logic [1:0] GRP_POLARITY = 2'd2;
	localparam logic [1:0] GRP_DIR      = 2'd3;

	localparam logic [7:0] DIR_RESET = 8'hFF;

	typedef logic [NUM_PORTS-1:0][PORT_W-1:0] port_bank_t;

	typedef struct packed {
		logic [1:0]  command;
		logic        start_req;
		logic [7:0]  control_byte;
		logic [7:0]  data;
		logic [31:0] pin_sel;
		logic        level;
	} item_t;

	typedef struct packed {
		logic [7:0] read_data;
		logic       int_pin_level;
		logic       int_event;
	} result_t;

	// controller to datapath
	typedef struct packed {
		logic load;
		logic exec;
	} ctl_cmd_t;

endpackage

// ===== src/io_expander_register_block_top.sv =====
// a request beat is captured on acceptance, executed in the execute state, and its result
// is registered and delivered in the response state, held there while rsp_stall holds
// the three-state controller takes a new beat only after the previous result is taken
// reset: arst_n asynchronous active low; clears all port registers, direction to 0xff,
// pointer, auto-increment and interrupt; no item in flight after reset
module io_expander_register_block_top (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               req_valid,
	output logic               req_stall,
	input  ioexp_pkg::item_t   req_beat,
	output logic               rsp_valid,
	input  logic               rsp_stall,
	output ioexp_pkg::result_t rsp_beat
);

	// command bundle from the sequencer to the register datapath
	ioexp_pkg::ctl_cmd_t cmd;

	// sequencer: idle -> execute -> response, one beat at a time
	ioexp_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.cmd       (cmd)
	);

	// register file, pointer logic, pin update and interrupt evaluation
	ioexp_dp u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd),
		.req_beat (req_beat),
		.rsp_beat (rsp_beat)
	);

endmodule

// ===== src/ioexp_ctrl.sv =====
module ioexp_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                req_valid,
	output logic                req_stall,
	output logic                rsp_valid,
	input  logic                rsp_stall,
	output ioexp_pkg::ctl_cmd_t cmd
);

	typedef enum logic [2:0] {
		S_IDLE = 3'b001,
		S_EXEC = 3'b010,
		S_RESP = 3'b100
	} state_t;

	state_t state_q, state_d;

	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (req_valid) state_d = S_EXEC;
			end
			S_EXEC: state_d = S_RESP;
			S_RESP: begin
				if (!rsp_stall) state_d = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	assign req_stall = (state_q != S_IDLE);
	assign rsp_valid = (state_q == S_RESP);
	assign cmd.load  = (state_q == S_IDLE) && req_valid;
	assign cmd.exec  = (state_q == S_EXEC);

endmodule

// ===== src/ioexp_dp.sv =====
module ioexp_dp (
	input  logic                clk,
	input  logic                arst_n,
	input  ioexp_pkg::ctl_cmd_t cmd,
	input  ioexp_pkg::item_t    req_beat,
	output ioexp_pkg::result_t  rsp_beat
);

	ioexp_pkg::item_t      item_q;
	ioexp_pkg::result_t    result_q;
	ioexp_pkg::port_bank_t in_q, last_q, out_q, pol_q, dir_q;
	ioexp_pkg::port_bank_t in_d, last_d, out_d, pol_d, dir_d;
	logic                  int_q, int_d;
	logic [7:0]            ptr_q, ptr_d, ptr_cur;
	logic                  ainc_q, ainc_d, ainc_cur;

	logic [1:0]                         port;
	logic [1:0]                         grp;
	logic                               mapped;
	logic [ioexp_pkg::PIN_COUNT-1:0]    pin_low, pin_oh;
	logic                               reeval, want, ev;
	logic [7:0]                         rd;

	always_comb begin
		in_d    = in_q;
		last_d  = last_q;
		out_d   = out_q;
		pol_d   = pol_q;
		dir_d   = dir_q;
		ptr_d   = ptr_q;
		ainc_d  = ainc_q;
		reeval  = 1'b0;
		rd      = '0;
		ptr_cur = item_q.start_req ? {1'b0, item_q.control_byte[6:0]} : ptr_q;
		ainc_cur = item_q.start_req ? item_q.control_byte[7] : ainc_q;
		port    = ptr_cur[1:0];
		grp     = ptr_cur[3:2];
		mapped  = (ptr_cur[7:4] == 4'd0) && (port != 2'd3);
		// isolate lowest set bit among the real pins
		pin_low = item_q.pin_sel[ioexp_pkg::PIN_COUNT-1:0];
		pin_oh  = pin_low & (~pin_low + 1'b1);

		case (item_q.command)
			ioexp_pkg::CMD_WRITE: begin
				if (mapped) begin
					case (grp)
						ioexp_pkg::GRP_OUTPUT:   out_d[port] = item_q.data;
						ioexp_pkg::GRP_POLARITY: pol_d[port] = item_q.data;
						ioexp_pkg::GRP_DIR: begin
							dir_d[port] = item_q.data;
							reeval      = 1'b1;
						end
						default: ;
					endcase
				end
				ptr_d  = ainc_cur ? ptr_cur + 8'd1 : ptr_cur;
				ainc_d = ainc_cur;
			end
			ioexp_pkg::CMD_READ: begin
				if (mapped) begin
					case (grp)
						ioexp_pkg::GRP_INPUT: begin
							last_d[port] = in_q[port];
							rd           = in_q[port] ^ pol_q[port];
							reeval       = 1'b1;
						end
						ioexp_pkg::GRP_OUTPUT:   rd = out_q[port];
						ioexp_pkg::GRP_POLARITY: rd = pol_q[port];
						default:                 rd = dir_q[port];
					endcase
				end
				ptr_d  = ainc_cur ? ptr_cur + 8'd1 : ptr_cur;
				ainc_d = ainc_cur;
			end
			ioexp_pkg::CMD_PIN: begin
				if (pin_low != '0) begin
					in_d   = item_q.level ? (in_q | pin_oh) : (in_q & ~pin_oh);
					reeval = 1'b1;
				end
			end
			default: ;
		endcase

		want  = |((in_d ^ last_d) & dir_d);
		ev    = reeval && want && !int_q;
		int_d = reeval ? want : int_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_q   <= '0;
			last_q <= '0;
			out_q  <= '0;
			pol_q  <= '0;
			dir_q  <= {ioexp_pkg::NUM_PORTS{ioexp_pkg::DIR_RESET}};
			int_q  <= 1'b0;
			ptr_q  <= '0;
			ainc_q <= 1'b0;
		end else if (cmd.exec) begin
			in_q   <= in_d;
			last_q <= last_d;
			out_q  <= out_d;
			pol_q  <= pol_d;
			dir_q  <= dir_d;
			int_q  <= int_d;
			ptr_q  <= ptr_d;
			ainc_q <= ainc_d;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			item_q <= req_beat;
		end
		if (cmd.exec) begin
			result_q.read_data     <= rd;
			result_q.int_pin_level <= ~int_d;
			result_q.int_event     <= ev;
		end
	end

	assign rsp_beat = result_q;

endmodule

// ===== src/ioexp_chk.sv =====
module ioexp_chk (
	input logic               clk,
	input logic               arst_n,
	input logic               req_valid,
	input logic               req_stall,
	input ioexp_pkg::item_t   req_beat,
	input logic               rsp_valid,
	input logic               rsp_stall,
	input ioexp_pkg::result_t rsp_beat
);

	// a result appears only for a beat taken earlier, with the execute state between them
	a_rsp_follows_req: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(rsp_valid) |-> $past(req_valid && !req_stall, 2))
		else $error("result without accepted request");

	// one item at a time: no new beat while a result is pending
	a_single_item: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> req_stall)
		else $error("request taken while result pending");

	// non-read commands return zero data
	a_nonread_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(req_valid && !req_stall && req_beat.command != ioexp_pkg::CMD_READ)
		|-> ##2 (rsp_beat.read_data == 8'd0))
		else $error("nonzero read data on non-read");

	// an interrupt event means the line is now active
	a_event_level: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid && rsp_beat.int_event) |-> !rsp_beat.int_pin_level)
		else $error("interrupt event with inactive line");

	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid && rsp_stall) |=> (rsp_valid && $stable(rsp_beat)))
		else $error("stalled result changed");

endmodule

bind io_expander_register_block_top ioexp_chk u_chk (.*);

// ===== bench/io_expander_register_block_checker.sv =====
`timescale 1ns / 100ps

module io_expander_register_block_checker (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               req_valid,
	input  logic               req_stall,
	input  ioexp_pkg::item_t   req_beat,
	input  logic               rsp_valid,
	input  logic               rsp_stall,
	input  ioexp_pkg::result_t rsp_beat,
	output int unsigned        mismatch_total,
	output int unsigned        results_owed,
	output int unsigned        results_checked,
	output int unsigned        int_assertions
);
	import ioexp_pkg::*;

	// shadow copy of the expander registers
	logic [PORT_W-1:0] pin_levels  [NUM_PORTS];
	logic [PORT_W-1:0] seen_levels [NUM_PORTS];
	logic [PORT_W-1:0] out_regs    [NUM_PORTS];
	logic [PORT_W-1:0] inv_regs    [NUM_PORTS];
	logic [PORT_W-1:0] dir_regs    [NUM_PORTS];
	logic              int_on;
	logic [7:0]        pointer;
	logic              incr_on;

	result_t     pending_results [$];
	int unsigned mismatches;
	int unsigned checked;
	int unsigned rises;

	// returns 1 only when the interrupt goes from idle to active
	function automatic logic refresh_interrupt();
		logic want;
		want = 1'b0;
		for (int p = 0; p < NUM_PORTS; p++)
			if (((pin_levels[p] ^ seen_levels[p]) & dir_regs[p]) != '0)
				want = 1'b1;
		if (want != int_on) begin
			int_on = want;
			return want;
		end
		return 1'b0;
	endfunction

	function automatic result_t next_expander_result(input item_t b);
		result_t    r;
		logic [1:0] grp;
		logic [1:0] port;
		int         pin;
		logic       hit;
		r   = '0;
		pin = 0;
		hit = 1'b0;
		case (b.command)
			CMD_WRITE, CMD_READ: begin
				if (b.start_req) begin
					pointer = {1'b0, b.control_byte[6:0]};
					incr_on = b.control_byte[7];
				end
				port = pointer[1:0];
				grp  = pointer[3:2];
				if (pointer[7:4] == 4'd0 && port < NUM_PORTS) begin
					if (b.command == CMD_WRITE) begin
						case (grp)
							GRP_OUTPUT:   out_regs[port] = b.data;
							GRP_POLARITY: inv_regs[port] = b.data;
							GRP_DIR: begin
								dir_regs[port] = b.data;
								r.int_event = refresh_interrupt();
							end
							default: ;
						endcase
					end else begin
						case (grp)
							GRP_INPUT: begin
								seen_levels[port] = pin_levels[port];
								r.read_data = pin_levels[port] ^ inv_regs[port];
								r.int_event = refresh_interrupt();
							end
							GRP_OUTPUT:   r.read_data = out_regs[port];
							GRP_POLARITY: r.read_data = inv_regs[port];
							default:      r.read_data = dir_regs[port];
						endcase
					end
				end
				if (incr_on)
					pointer = pointer + 8'd1;
			end
			CMD_PIN: begin
				// lowest set bit picks the pin
				for (int i = 31; i >= 0; i--)
					if (b.pin_sel[i]) begin
						pin = i;
						hit = 1'b1;
					end
				if (hit && pin < PIN_COUNT) begin
					pin_levels[pin / PORT_W][pin % PORT_W] = b.level;
					r.int_event = refresh_interrupt();
				end
			end
			default: ;
		endcase
		r.int_pin_level = ~int_on;
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin : watch
		result_t want;
		if (!arst_n) begin
			for (int p = 0; p < NUM_PORTS; p++) begin
				pin_levels[p]  = '0;
				seen_levels[p] = '0;
				out_regs[p]    = '0;
				inv_regs[p]    = '0;
				dir_regs[p]    = DIR_RESET;
			end
			int_on   = 1'b0;
			pointer  = '0;
			incr_on  = 1'b0;
			pending_results.delete();
			mismatches = 0;
			checked    = 0;
			rises      = 0;
		end else begin
			if (rsp_valid && !rsp_stall) begin
				checked++;
				if (rsp_beat.int_event === 1'b1)
					rises++;
				if (pending_results.size() == 0) begin
					if (mismatches < 10)
						$display("%0t: result with nothing expected: rd=%02h int=%b ev=%b",
							$time, rsp_beat.read_data, rsp_beat.int_pin_level,
							rsp_beat.int_event);
					mismatches++;
				end else begin
					want = pending_results.pop_front();
					if (rsp_beat.read_data !== want.read_data
							|| rsp_beat.int_pin_level !== want.int_pin_level
							|| rsp_beat.int_event !== want.int_event) begin
						if (mismatches < 10)
							$display("%0t: mismatch: expected rd=%02h int=%b ev=%b, got rd=%02h int=%b ev=%b",
								$time, want.read_data, want.int_pin_level, want.int_event,
								rsp_beat.read_data, rsp_beat.int_pin_level,
								rsp_beat.int_event);
						mismatches++;
					end
				end
			end
			if (req_valid && !req_stall)
				pending_results.push_back(next_expander_result(req_beat));
		end
		mismatch_total  <= mismatches;
		results_owed    <= pending_results.size();
		results_checked <= checked;
		int_assertions  <= rises;
	end

endmodule

// ===== bench/tb_io_expander_register_block_top.sv =====
`timescale 1ns / 100ps

module tb_io_expander_register_block_top;
	import ioexp_pkg::*;

	localparam int unsigned QUIET_LIMIT  = 1000; // cycles with no beat moving on either side
	localparam int unsigned DRAIN_CYCLES = 8;    // extra cycles run after the last result returns
	localparam int unsigned PHASE_BEATS  = 175;
	localparam int unsigned WRAP_BEATS   = 133;  // 0x7f up through 0xff, wrap, a few more
	localparam logic [1:0]  PORT_NONE    = 2'd3; // port slot 3 of every group is unmapped
	localparam logic [6:0]  ADDR_TOP     = 7'h7F;

	logic    clk;
	logic    arst_n    = 1'b0;
	logic    req_valid = 1'b0;
	logic    req_stall;
	item_t   req_beat  = '0;
	logic    rsp_valid;
	logic    rsp_stall = 1'b0;
	result_t rsp_beat;

	// idle and stall odds out of a hundred, changed per phase
	int unsigned send_idle_pct = 0;
	int unsigned stall_pct     = 0;
	int unsigned beats_sent    = 0;
	int unsigned quiet_cycles  = 0;
	int unsigned cmd_count [4] = '{default: 0};

	int unsigned mismatch_total;
	int unsigned results_owed;
	int unsigned results_checked;
	int unsigned int_assertions;

	io_expander_register_block_top uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req_beat  (req_beat),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp_beat  (rsp_beat)
	);

	io_expander_register_block_checker u_check (
		.clk             (clk),
		.arst_n          (arst_n),
		.req_valid       (req_valid),
		.req_stall       (req_stall),
		.req_beat        (req_beat),
		.rsp_valid       (rsp_valid),
		.rsp_stall       (rsp_stall),
		.rsp_beat        (rsp_beat),
		.mismatch_total  (mismatch_total),
		.results_owed    (results_owed),
		.results_checked (results_checked),
		.int_assertions  (int_assertions)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// result side back-pressure, fresh coin every cycle
	always @(posedge clk) begin
		rsp_stall <= ($urandom_range(99) < stall_pct);
	end

	// watchdog: a hung handshake ends the run
	always @(posedge clk) begin
		if (arst_n) begin
			if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall))
				quiet_cycles <= 0;
			else if (quiet_cycles + 1 >= QUIET_LIMIT) begin
				$display("watchdog: no beat moved for %0d cycles", QUIET_LIMIT);
				$display("RESULT: ERROR");
				$finish;
			end else
				quiet_cycles <= quiet_cycles + 1;
		end
	end

	// control byte from auto-increment flag, register group and port
	function automatic logic [7:0] ctl_byte(input logic ai, input logic [1:0] grp,
			input logic [1:0] port);
		return {ai, 3'b000, grp, port};
	endfunction

	// data bytes lean on the all-zero and all-one extremes now and then
	function automatic logic [7:0] pick_data();
		case ($urandom_range(9))
			0:       return 8'h00;
			1:       return 8'hFF;
			default: return 8'($urandom);
		endcase
	endfunction

	// lowest set bit lands on the given pin, bits above it are random
	function automatic logic [31:0] mask_for_pin(input int unsigned pin);
		logic [31:0] m;
		m      = $urandom;
		m      = m & ~((32'h1 << pin) - 32'h1);
		m[pin] = 1'b1;
		return m;
	endfunction

	// bus byte; the pin fields ride along with random content
	function automatic item_t bus_item(input logic [1:0] cmd, input logic start,
			input logic [7:0] ctrl, input logic [7:0] data);
		item_t b;
		b.command      = cmd;
		b.start_req    = start;
		b.control_byte = ctrl;
		b.data         = data;
		b.pin_sel      = $urandom;
		b.level        = 1'($urandom);
		return b;
	endfunction

	// pin event; the bus fields ride along with random content
	function automatic item_t pin_item(input logic [31:0] mask, input logic lvl);
		item_t b;
		b.command      = CMD_PIN;
		b.start_req    = 1'($urandom);
		b.control_byte = 8'($urandom);
		b.data         = 8'($urandom);
		b.pin_sel      = mask;
		b.level        = lvl;
		return b;
	endfunction

	// present one beat, with random idle cycles ahead of it, and hold it until taken
	task automatic send_item(input item_t b);
		while ($urandom_range(99) < send_idle_pct) begin
			req_valid <= 1'b0;
			@(posedge clk);
		end
		req_valid <= 1'b1;
		req_beat  <= b;
		@(posedge clk);
		while (req_stall)
			@(posedge clk);
		beats_sent++;
		cmd_count[b.command]++;
	endtask

	// one bus transfer: a start byte, then bytes that follow the pointer
	task automatic transfer(input logic [1:0] cmd, input logic [7:0] ctrl,
			input int unsigned len);
		send_item(bus_item(cmd, 1'b1, ctrl, pick_data()));
		repeat (len - 1)
			send_item(bus_item(cmd, 1'b0, 8'($urandom), pick_data()));
	endtask

	// stop sending and let every owed result come back
	task automatic wait_all_results();
		req_valid <= 1'b0;
		@(posedge clk);
		while (results_owed != 0)
			@(posedge clk);
	endtask

	initial begin : stimulus
		item_t       b;
		int unsigned phase;
		int unsigned first;
		int unsigned sel;
		int unsigned pick;
		logic [1:0]  c;

		repeat (11) @(posedge clk);
		arst_n <= 1'b1;

		// ---- directed part ----
		// no start byte yet: pointer and auto-increment are still zero, reads input 0
		send_item(bus_item(CMD_READ, 1'b0, 8'hFF, 8'h00));
		// auto-increment write burst through the output group and past its end
		send_item(bus_item(CMD_WRITE, 1'b1, ctl_byte(1'b1, GRP_OUTPUT, 2'd0), 8'hFF));
		send_item(bus_item(CMD_WRITE, 1'b0, 8'h00, 8'h00));
		send_item(bus_item(CMD_WRITE, 1'b0, 8'hFF, 8'hA5));
		// unmapped slot, write dropped; pointer runs on into polarity 0
		send_item(bus_item(CMD_WRITE, 1'b0, 8'h00, 8'h5A));
		send_item(bus_item(CMD_WRITE, 1'b0, 8'h00, 8'hFF));
		// input ports are read only
		send_item(bus_item(CMD_WRITE, 1'b1, ctl_byte(1'b0, GRP_INPUT, 2'd2), 8'hFF));
		// pin events that must be ignored: empty mask, lowest bit at 24 and at 31
		send_item(pin_item(32'h0000_0000, 1'b1));
		send_item(pin_item(32'h0100_0000, 1'b1));
		send_item(pin_item(32'h8000_0000, 1'b1));
		// all-ones mask selects pin 0, interrupt goes active
		send_item(pin_item(32'hFFFF_FFFF, 1'b1));
		// pin event with start flag and a full control byte: pointer must stay put
		b              = pin_item(32'hFFFF_FF00, 1'b1);
		b.start_req    = 1'b1;
		b.control_byte = 8'hFF;
		send_item(b);
		// top pin of the last port
		send_item(pin_item(32'h0080_0000, 1'b1));
		// no start: pointer still on input 2 from the dropped write
		send_item(bus_item(CMD_READ, 1'b0, 8'h00, 8'h00));
		// read all inputs with auto-increment; polarity 0 inverts port 0
		send_item(bus_item(CMD_READ, 1'b1, ctl_byte(1'b1, GRP_INPUT, 2'd0), 8'h00));
		send_item(bus_item(CMD_READ, 1'b0, 8'h00, 8'h00));
		send_item(bus_item(CMD_READ, 1'b0, 8'h00, 8'h00));
		// unmapped slot after the input group reads zero
		send_item(bus_item(CMD_READ, 1'b0, 8'h00, 8'h00));
		// mask off port 0, change pin 0: no interrupt
		send_item(bus_item(CMD_WRITE, 1'b1, ctl_byte(1'b0, GRP_DIR, 2'd0), 8'h00));
		send_item(pin_item(32'h0000_0001, 1'b0));
		// unmasking again raises it on the direction write itself
		send_item(bus_item(CMD_WRITE, 1'b1, ctl_byte(1'b0, GRP_DIR, 2'd0), 8'hFF));
		// read back output 1, output 2 and the hole after them
		send_item(bus_item(CMD_READ, 1'b1, ctl_byte(1'b1, GRP_OUTPUT, 2'd1), 8'h00));
		send_item(bus_item(CMD_READ, 1'b0, 8'h00, 8'h00));
		send_item(bus_item(CMD_READ, 1'b0, ctl_byte(1'b0, GRP_DIR, PORT_NONE), 8'h00));
		// highest address, unmapped, auto-increment carries the pointer to 0x80
		send_item(bus_item(CMD_READ, 1'b1, {1'b1, ADDR_TOP}, 8'h00));
		// no-op with every field at an extreme
		b          = bus_item(CMD_NOP, 1'b1, 8'h00, 8'hFF);
		b.pin_sel  = 32'hFFFF_FFFF;
		b.level    = 1'b1;
		send_item(b);
		wait_all_results();

		// ---- random part, four traffic mixes ----
		for (phase = 0; phase < 4; phase++) begin
			case (phase)
				0: begin
					send_idle_pct = 0;
					stall_pct     = 0;
				end
				1: begin
					send_idle_pct = 46;
					stall_pct     = 0;
				end
				2: begin
					send_idle_pct = 0;
					stall_pct     = 46;
				end
				default: begin
					send_idle_pct = 12;
					stall_pct     = 12;
				end
			endcase

			// long auto-increment read from 0x7f: pointer wraps from 0xff to 0x00
			if (phase == 1)
				transfer(CMD_READ, {1'b1, ADDR_TOP}, WRAP_BEATS);

			first = beats_sent;
			while (beats_sent - first < PHASE_BEATS) begin
				sel = $urandom_range(99);
				c   = $urandom_range(1) ? CMD_READ : CMD_WRITE;
				if (sel < 45) begin
					// well-formed transfer, mostly to mapped registers
					if ($urandom_range(99) < 85)
						transfer(c, ctl_byte($urandom_range(99) < 70, 2'($urandom),
							2'($urandom_range(2))), $urandom_range(1, 6));
					else
						transfer(c, 8'($urandom), $urandom_range(1, 6));
				end else if (sel < 75) begin
					// burst of pin events, a few of them meant to be ignored
					repeat ($urandom_range(1, 4)) begin
						pick = $urandom_range(19);
						if (pick == 0)
							send_item(pin_item(32'h0, 1'($urandom)));
						else if (pick < 3)
							send_item(pin_item(mask_for_pin($urandom_range(31, 24)),
								1'($urandom)));
						else
							send_item(pin_item(mask_for_pin($urandom_range(23)),
								1'($urandom)));
					end
				end else if (sel < 85)
					// scan all inputs, clears the interrupt
					transfer(CMD_READ, ctl_byte(1'b1, GRP_INPUT, 2'd0), 3);
				else if (sel < 95)
					// noise, any command with any fields
					send_item(bus_item(2'($urandom_range(3)), 1'($urandom), 8'($urandom),
						8'($urandom)));
				else
					// stray byte with no start in front of it
					send_item(bus_item(c, 1'b0, 8'($urandom), pick_data()));
			end

			// sender holds off until the block has answered everything
			wait_all_results();
		end

		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("covered %0d beats: %0d writes, %0d reads, %0d pin events, %0d no-ops",
			beats_sent, cmd_count[CMD_WRITE], cmd_count[CMD_READ], cmd_count[CMD_PIN],
			cmd_count[CMD_NOP]);
		$display("checked %0d results, %0d interrupt assertions, %0d mismatches, %0d missing",
			results_checked, int_assertions, mismatch_total, results_owed);
		if (mismatch_total == 0 && results_owed == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule

// ===== io_expander_register_block_top.f =====
src/ioexp_pkg.sv
src/ioexp_ctrl.sv
src/ioexp_dp.sv
src/io_expander_register_block_top.sv
src/ioexp_chk.sv
bench/io_expander_register_block_checker.sv
bench/tb_io_expander_register_block_top.sv
